// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Widths and defaults shared by the even-sum submatrix counter.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int SIDE_W       = 7;
  localparam int COUNT_W      = 23;
  localparam int MAX_SIDE_DEF = 64;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(1);

endpackage

`default_nettype wire

// ----- rtl/even_sum_submatrix_counter_core.sv -----
// ----------------------------------------------------------------------------
// even_sum_submatrix_counter_core
// Loads a square 0/1 matrix into a prefix-parity map and counts the
// submatrices whose element sum is even.
//
//   Channel  Signals                                    Transfer
//   input    start, busy, in_cell_value, in_last_cell   start high and busy low
//   result   out_strobe, out_even_count                 out_strobe high, one cycle
//   config   cfg_write_en, cfg_side_length              cfg_write_en high
//
// For each cell the neighbouring parities are read, then its parity is written.
// After a side change the column is recomputed by a serial divider, one
// position bit at a time. Missing cells are filled as zero cells, then the
// count walks the map at one column per cycle, with two map copies read in
// parallel. The map needs no clearing after reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module even_sum_submatrix_counter_core
  import esc_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_cell_value,
  input  wire logic               in_last_cell,
  output logic                    out_strobe,
  output logic [COUNT_W-1:0]      out_even_count,
  input  wire logic               cfg_write_en,
  input  wire logic [SIDE_W-1:0]  cfg_side_length
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int KW    = $clog2(MAX_SIDE + 2);
  localparam int PW2   = 2 * KW;
  localparam int DCW   = (CW > 1) ? $clog2(CW) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ISSUE, ST_WR, ST_CINIT, ST_CRUN, ST_CDRAIN
  } state_t;

  state_t            state_r;
  logic [SIDE_W-1:0] side_cfg_r;
  logic [CW-1:0]     pos_r;
  logic [IW-1:0]     col_r;
  logic [SW-1:0]     div_side_r;
  logic [SW-1:0]     s_cur_r;
  logic [CW-1:0]     cells_r;
  logic              v_r;
  logic              last_pend_r;
  logic              last_par_r;
  logic [SW-1:0]     rem_r;
  logic [DCW-1:0]    div_cnt_r;
  logic [IW-1:0]     top_r, bot_r, j_r;
  logic [AW-1:0]     a_addr_r, bb_r, tb_r;
  logic              p1_v_r, p1_mask_r, p1_end_r, p1_fin_r;
  logic [KW-1:0]     c1acc_r;
  logic              band_v_r, band_fin_r;
  logic [KW-1:0]     band_c1_r;
  logic [COUNT_W-1:0] total_r;
  logic              out_strobe_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [SW-1:0]     eff_s;
  logic [CW-1:0]     eff_cells;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic              q_a, q_b;
  logic              wr_en;
  logic              rpos, cpos, par_new;
  logic [SW:0]       rem_shift, rem_new;
  logic              j_last, bot_last, top_last;
  logic              cell_bit;
  logic [KW-1:0]     c0;
  logic [PW2-1:0]    prod0, prod1;
  logic [COUNT_W-1:0] term;

  always_comb begin
    if (side_cfg_r == '0) begin
      eff_s = SW'(1);
    end else if (int'(side_cfg_r) > MAX_SIDE) begin
      eff_s = SW'(MAX_SIDE);
    end else begin
      eff_s = SW'(side_cfg_r);
    end
  end

  assign eff_cells = CW'(CW'(eff_s) * CW'(eff_s));

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        raddr_a = AW'(pos_r - CW'(eff_s));
        raddr_b = AW'(pos_r - CW'(eff_s) - CW'(1));
      end
      ST_ISSUE: begin
        raddr_a = AW'(pos_r - CW'(s_cur_r));
        raddr_b = AW'(pos_r - CW'(s_cur_r) - CW'(1));
      end
      ST_CRUN: begin
        raddr_a = a_addr_r;
        raddr_b = AW'(bb_r + AW'(j_r));
      end
      default: begin
        raddr_a = a_addr_r;
        raddr_b = bb_r;
      end
    endcase
  end

  assign wr_en   = (state_r == ST_WR);
  assign rpos    = (pos_r >= CW'(s_cur_r));
  assign cpos    = (col_r != '0);
  assign par_new = v_r ^ (cpos & last_par_r) ^ (rpos & q_a) ^ (rpos & cpos & q_b);

  esc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(pos_r)),
    .wdata (par_new),
    .raddr (raddr_a),
    .rdata (q_a)
  );

  esc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(pos_r)),
    .wdata (par_new),
    .raddr (raddr_b),
    .rdata (q_b)
  );

  assign rem_shift = {rem_r, pos_r[div_cnt_r]};
  assign rem_new   = (rem_shift >= (SW+1)'(s_cur_r)) ? rem_shift - (SW+1)'(s_cur_r)
                                                     : rem_shift;

  assign j_last   = ((SW'(j_r) + SW'(1)) == s_cur_r);
  assign bot_last = ((SW'(bot_r) + SW'(1)) == s_cur_r);
  assign top_last = ((SW'(top_r) + SW'(1)) == s_cur_r);

  assign cell_bit = q_a ^ (p1_mask_r & q_b);
  assign c0       = KW'(KW'(s_cur_r) + KW'(1) - band_c1_r);
  assign prod0    = PW2'(c0) * PW2'(c0 - KW'(1));
  assign prod1    = PW2'(band_c1_r) * PW2'(band_c1_r - KW'(1));
  assign term     = COUNT_W'(prod0 >> 1) + COUNT_W'(prod1 >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      side_cfg_r   <= SIDE_RESET;
      pos_r        <= '0;
      col_r        <= '0;
      div_side_r   <= SW'(1);
      p1_v_r       <= 1'b0;
      band_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      out_count_r  <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_write_en) begin
        side_cfg_r <= cfg_side_length;
      end

      p1_v_r   <= 1'b0;
      band_v_r <= 1'b0;
      if (p1_v_r) begin
        if (p1_end_r) begin
          band_c1_r  <= c1acc_r + KW'(cell_bit);
          band_fin_r <= p1_fin_r;
          band_v_r   <= 1'b1;
          c1acc_r    <= '0;
        end else begin
          c1acc_r <= c1acc_r + KW'(cell_bit);
        end
      end
      if (band_v_r) begin
        total_r <= total_r + term;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            v_r         <= in_cell_value;
            last_pend_r <= in_last_cell;
            s_cur_r     <= eff_s;
            cells_r     <= eff_cells;
            if (pos_r < eff_cells) begin
              if (eff_s == div_side_r) begin
                state_r <= ST_WR;
              end else begin
                rem_r     <= '0;
                div_cnt_r <= DCW'(CW - 1);
                state_r   <= ST_DIV;
              end
            end else if (in_last_cell) begin
              state_r <= ST_CINIT;
            end
          end
        end
        ST_DIV: begin
          rem_r     <= SW'(rem_new);
          div_cnt_r <= div_cnt_r - DCW'(1);
          if (div_cnt_r == '0) begin
            col_r      <= IW'(rem_new);
            div_side_r <= s_cur_r;
            state_r    <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WR;
        end
        ST_WR: begin
          last_par_r <= par_new;
          pos_r      <= pos_r + CW'(1);
          col_r      <= ((SW'(col_r) + SW'(1)) == s_cur_r) ? '0 : col_r + IW'(1);
          if (!last_pend_r) begin
            state_r <= ST_IDLE;
          end else if ((pos_r + CW'(1)) < cells_r) begin
            v_r     <= 1'b0;
            state_r <= ST_ISSUE;
          end else begin
            state_r <= ST_CINIT;
          end
        end
        ST_CINIT: begin
          top_r    <= '0;
          bot_r    <= '0;
          j_r      <= '0;
          a_addr_r <= '0;
          bb_r     <= '0;
          tb_r     <= '0;
          total_r  <= '0;
          c1acc_r  <= '0;
          state_r  <= ST_CRUN;
        end
        ST_CRUN: begin
          p1_v_r    <= 1'b1;
          p1_mask_r <= (top_r != '0);
          p1_end_r  <= j_last;
          p1_fin_r  <= j_last & bot_last & top_last;
          if (!j_last) begin
            j_r      <= j_r + IW'(1);
            a_addr_r <= a_addr_r + AW'(1);
          end else begin
            j_r <= '0;
            if (!bot_last) begin
              bot_r    <= bot_r + IW'(1);
              a_addr_r <= a_addr_r + AW'(1);
            end else if (!top_last) begin
              top_r    <= top_r + IW'(1);
              bot_r    <= top_r + IW'(1);
              a_addr_r <= AW'(tb_r + AW'(s_cur_r));
              tb_r     <= AW'(tb_r + AW'(s_cur_r));
              bb_r     <= tb_r;
            end else begin
              state_r <= ST_CDRAIN;
            end
          end
        end
        ST_CDRAIN: begin
          if (band_v_r && band_fin_r) begin
            out_count_r  <= total_r + term;
            out_strobe_r <= 1'b1;
            pos_r        <= '0;
            col_r        <= '0;
            div_side_r   <= s_cur_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_even_count = out_count_r;

  `ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `ASSERT_SAME(a_write_in_range, clk, rst_n, state_r == ST_WR, pos_r < cells_r)
  `ASSERT_SAME(a_col_in_range, clk, rst_n, 1'b1, SW'(col_r) < div_side_r)
  `ASSERT_NEXT(a_no_early_result, clk, rst_n, start && !busy && !in_last_cell, !out_strobe)

endmodule

`default_nettype wire

// ----- rtl/esc_ram.sv -----
// ----------------------------------------------------------------------------
// esc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
